[design/bdc_pkg.sv]
`timescale 1ns / 1ps

package bdc_pkg;

    // Configuration port geometry.
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE_TICKS    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_MULTICLICK_GAP    = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_HOLD_AFTER_A      = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_HOLD_AFTER_B      = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_CLICK_TARGET_A    = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_CLICK_TARGET_B    = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_LONGPRESS_ENABLE  = 3'd6;
    localparam logic [CfgIndexWidth-1:0] REG_MULTICLICK_ENABLE = 3'd7;

    // Register values after reset.
    localparam logic [7:0]  DEBOUNCE_TICKS_RST    = 8'd30;
    localparam logic [7:0]  MULTICLICK_GAP_RST    = 8'd200;
    localparam logic [15:0] HOLD_AFTER_A_RST      = 16'd1000;
    localparam logic [15:0] HOLD_AFTER_B_RST      = 16'd3000;
    localparam logic [3:0]  CLICK_TARGET_A_RST    = 4'd2;
    localparam logic [3:0]  CLICK_TARGET_B_RST    = 4'd3;
    localparam logic [1:0]  LONGPRESS_ENABLE_RST  = 2'd0;
    localparam logic [1:0]  MULTICLICK_ENABLE_RST = 2'd0;

    // Saturation limits of the timers and the click counter.
    localparam logic [7:0]  GAP_MAX      = 8'hFF;
    localparam logic [7:0]  DEBOUNCE_MAX = 8'hFF;
    localparam logic [15:0] HELD_MAX     = 16'hFFFF;
    localparam logic [3:0]  CLICK_MAX    = 4'hF;

    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [7:0]  multiclick_gap;
        logic [15:0] hold_after_a;
        logic [15:0] hold_after_b;
        logic [3:0]  click_target_a;
        logic [3:0]  click_target_b;
        logic [1:0]  longpress_enable;
        logic [1:0]  multiclick_enable;
    } bdc_cfg_t;

    typedef struct packed {
        logic        press_fired;
        logic        release_fired;
        logic        hold_fired;
        logic [1:0]  longpress_fired;
        logic [1:0]  multiclick_fired;
        logic [15:0] press_length;
        logic [15:0] current_length;
        logic [3:0]  click_tally;
    } bdc_result_t;

endpackage

[design/button_debounce_click_detector.sv]
`timescale 1ns / 1ps
// Each input beat is taken into the input register, then its result into
// the result register, which offers it until taken. One beat per cycle
// while out_stall is low; the tracker state updates once per beat.
// Reset (rst_n low, asynchronous) empties both registers, returns the
// configuration to its defaults and puts the tracker idle with the gap expired.

module button_debounce_click_detector
    import bdc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     pin_level,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     press_fired,
    output logic                     release_fired,
    output logic                     hold_fired,
    output logic [1:0]               longpress_fired,
    output logic [1:0]               multiclick_fired,
    output logic [15:0]              press_length,
    output logic [15:0]              current_length,
    output logic [3:0]               click_tally
);

    bdc_cfg_t    cfg;
    bdc_result_t step_result;
    bdc_result_t result_reg;
    logic        in_valid_reg;
    logic        pin_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        advance;

    bdc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the result register frees when empty or being taken.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            pin_reg <= pin_level;
        end
    end

    bdc_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .pin     (pin_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign press_fired      = result_reg.press_fired;
    assign release_fired    = result_reg.release_fired;
    assign hold_fired       = result_reg.hold_fired;
    assign longpress_fired  = result_reg.longpress_fired;
    assign multiclick_fired = result_reg.multiclick_fired;
    assign press_length     = result_reg.press_length;
    assign current_length   = result_reg.current_length;
    assign click_tally      = result_reg.click_tally;

endmodule

[design/bdc_cfg_regs.sv]
`timescale 1ns / 1ps

module bdc_cfg_regs
    import bdc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    output bdc_cfg_t                 cfg
);

    bdc_cfg_t cfg_reg;

    // Register file; each register keeps the low bits of the write data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks    <= DEBOUNCE_TICKS_RST;
            cfg_reg.multiclick_gap    <= MULTICLICK_GAP_RST;
            cfg_reg.hold_after_a      <= HOLD_AFTER_A_RST;
            cfg_reg.hold_after_b      <= HOLD_AFTER_B_RST;
            cfg_reg.click_target_a    <= CLICK_TARGET_A_RST;
            cfg_reg.click_target_b    <= CLICK_TARGET_B_RST;
            cfg_reg.longpress_enable  <= LONGPRESS_ENABLE_RST;
            cfg_reg.multiclick_enable <= MULTICLICK_ENABLE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS:    cfg_reg.debounce_ticks    <= cfg_data[7:0];
                REG_MULTICLICK_GAP:    cfg_reg.multiclick_gap    <= cfg_data[7:0];
                REG_HOLD_AFTER_A:      cfg_reg.hold_after_a      <= cfg_data;
                REG_HOLD_AFTER_B:      cfg_reg.hold_after_b      <= cfg_data;
                REG_CLICK_TARGET_A:    cfg_reg.click_target_a    <= cfg_data[3:0];
                REG_CLICK_TARGET_B:    cfg_reg.click_target_b    <= cfg_data[3:0];
                REG_LONGPRESS_ENABLE:  cfg_reg.longpress_enable  <= cfg_data[1:0];
                REG_MULTICLICK_ENABLE: cfg_reg.multiclick_enable <= cfg_data[1:0];
                default:               cfg_reg.debounce_ticks    <= cfg_reg.debounce_ticks;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/bdc_step.sv]
`timescale 1ns / 1ps

module bdc_step
    import bdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        pin,
    input  bdc_cfg_t    cfg,
    output bdc_result_t result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CONFIRM_PRESS,
        PH_PRESSED,
        PH_CONFIRM_RELEASE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  debounce_reg, debounce_next;
    logic [15:0] held_reg, held_next;
    logic [7:0]  gap_reg, gap_next;
    logic [3:0]  click_reg, click_next;
    logic [1:0]  lp_done_reg, lp_done_next;
    logic [1:0]  mc_done_reg, mc_done_next;
    logic [15:0] last_len_reg, last_len_next;

    logic [7:0]  gap_adv;
    logic [15:0] held_adv;
    logic [7:0]  debounce_adv;
    logic [4:0]  want_clicks;
    logic        debounce_done;
    logic        press_ev, release_ev, hold_ev;
    logic [1:0]  lp_ev, mc_ev;

    // Timers advance first, with saturation.
    always_comb
    begin
        gap_adv = (gap_reg == GAP_MAX) ? GAP_MAX : gap_reg + 8'd1;
        held_adv = held_reg;
        if (phase_reg == PH_PRESSED || phase_reg == PH_CONFIRM_RELEASE)
        begin
            held_adv = (held_reg == HELD_MAX) ? HELD_MAX : held_reg + 16'd1;
        end
        debounce_adv = debounce_reg;
        if (phase_reg == PH_CONFIRM_PRESS || phase_reg == PH_CONFIRM_RELEASE)
        begin
            debounce_adv = (debounce_reg == DEBOUNCE_MAX) ? DEBOUNCE_MAX
                                                          : debounce_reg + 8'd1;
        end
    end

    assign want_clicks   = {1'b0, click_reg} + 5'd1;
    assign debounce_done = (debounce_adv >= cfg.debounce_ticks);

    // Phase logic on the advanced timer values.
    always_comb
    begin
        phase_next    = phase_reg;
        debounce_next = debounce_adv;
        held_next     = held_adv;
        gap_next      = gap_adv;
        click_next    = click_reg;
        lp_done_next  = lp_done_reg;
        mc_done_next  = mc_done_reg;
        last_len_next = last_len_reg;
        press_ev      = 1'b0;
        release_ev    = 1'b0;
        hold_ev       = 1'b0;
        lp_ev         = 2'b00;
        mc_ev         = 2'b00;

        unique case (phase_reg)
            PH_IDLE:
            begin
                // Series over: fire matching multi-click events once.
                if (gap_adv > cfg.multiclick_gap)
                begin
                    mc_ev[0] = cfg.multiclick_enable[0] && !mc_done_reg[0]
                               && ({1'b0, cfg.click_target_a} == want_clicks);
                    mc_ev[1] = cfg.multiclick_enable[1] && !mc_done_reg[1]
                               && ({1'b0, cfg.click_target_b} == want_clicks);
                    mc_done_next = mc_done_reg | mc_ev;
                end
                if (pin)
                begin
                    debounce_next = 8'd0;
                    phase_next    = PH_CONFIRM_PRESS;
                end
            end
            PH_CONFIRM_PRESS:
            begin
                if (debounce_done)
                begin
                    if (pin)
                    begin
                        held_next = 16'd0;
                        if (gap_adv <= cfg.multiclick_gap)
                        begin
                            click_next = (click_reg == CLICK_MAX) ? CLICK_MAX
                                                                  : click_reg + 4'd1;
                        end
                        else
                        begin
                            click_next   = 4'd0;
                            mc_done_next = 2'b00;
                        end
                        press_ev   = 1'b1;
                        phase_next = PH_PRESSED;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_PRESSED:
            begin
                if (!pin)
                begin
                    debounce_next = 8'd0;
                    phase_next    = PH_CONFIRM_RELEASE;
                end
                else
                begin
                    hold_ev  = 1'b1;
                    lp_ev[0] = cfg.longpress_enable[0] && !lp_done_reg[0]
                               && (held_adv >= cfg.hold_after_a);
                    lp_ev[1] = cfg.longpress_enable[1] && !lp_done_reg[1]
                               && (held_adv >= cfg.hold_after_b);
                    lp_done_next = lp_done_reg | lp_ev;
                end
            end
            PH_CONFIRM_RELEASE:
            begin
                if (debounce_done)
                begin
                    if (!pin)
                    begin
                        last_len_next = held_adv;
                        lp_done_next  = 2'b00;
                        held_next     = 16'd0;
                        gap_next      = 8'd0;
                        release_ev    = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_PRESSED;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Tracker state moves only when a beat passes to the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            debounce_reg <= 8'd0;
            held_reg     <= 16'd0;
            gap_reg      <= GAP_MAX;
            click_reg    <= 4'd0;
            lp_done_reg  <= 2'b00;
            mc_done_reg  <= 2'b00;
            last_len_reg <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            debounce_reg <= debounce_next;
            held_reg     <= held_next;
            gap_reg      <= gap_next;
            click_reg    <= click_next;
            lp_done_reg  <= lp_done_next;
            mc_done_reg  <= mc_done_next;
            last_len_reg <= last_len_next;
        end
    end

    // Result of the beat being processed.
    always_comb
    begin
        result.press_fired      = press_ev;
        result.release_fired    = release_ev;
        result.hold_fired       = hold_ev;
        result.longpress_fired  = lp_ev;
        result.multiclick_fired = mc_ev;
        result.press_length     = last_len_next;
        result.current_length   = held_next;
        result.click_tally      = click_next;
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import bdc_pkg::*;

    typedef enum logic [1:0] {
        TRK_IDLE,
        TRK_CONFIRM_PRESS,
        TRK_PRESSED,
        TRK_CONFIRM_RELEASE
    } trk_phase_t;

    localparam int QuietLimit    = 2000;
    localparam int HoldOffCycles = 300;
    localparam int TailCycles    = 8;
    localparam int RandomPhases  = 6;
    localparam int PhaseBeats    = 80;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic                     pin_level = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     press_fired;
    logic                     release_fired;
    logic                     hold_fired;
    logic [1:0]               longpress_fired;
    logic [1:0]               multiclick_fired;
    logic [15:0]              press_length;
    logic [15:0]              current_length;
    logic [3:0]               click_tally;

    bdc_result_t seen;
    assign seen = {press_fired, release_fired, hold_fired, longpress_fired, multiclick_fired,
                   press_length, current_length, click_tally};

    button_debounce_click_detector dut (
        .clk,
        .rst_n,
        .cfg_write,
        .cfg_index,
        .cfg_data,
        .in_valid,
        .in_stall,
        .pin_level,
        .out_valid,
        .out_stall,
        .press_fired,
        .release_fired,
        .hold_fired,
        .longpress_fired,
        .multiclick_fired,
        .press_length,
        .current_length,
        .click_tally
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Tracker copy used to predict each result beat.
    bdc_cfg_t    trk_cfg;
    trk_phase_t  trk_phase;
    logic [7:0]  trk_debounce;
    logic [15:0] trk_held;
    logic [7:0]  trk_gap;
    logic [3:0]  trk_clicks;
    logic [1:0]  trk_lp_done;
    logic [1:0]  trk_mc_done;
    logic [15:0] trk_last_len;

    logic        pin_samples[$];
    bdc_result_t expected_events[$];
    bdc_result_t wanted;
    int          samples_queued = 0;
    int          samples_taken  = 0;
    int          mismatch_count = 0;
    int          burst_left     = 0;
    int          gap_left       = 0;
    int          hold_off_req   = 0;
    int          hold_off_done  = 0;
    int          hold_left      = 0;
    int          stall_run      = 0;
    logic        stall_level    = 1'b0;
    int          quiet_cycles   = 0;

    // Advance the tracker by one tick and return the events it reports.
    function automatic bdc_result_t tracker_tick(input logic pin);
        bdc_result_t r;
        trk_phase_t  nxt;
        logic [4:0]  want;
        r    = '0;
        nxt  = trk_phase;
        want = {1'b0, trk_clicks} + 5'd1;

        // Timers advance first; the phase logic sees the advanced values.
        if (trk_gap != GAP_MAX)
            trk_gap = trk_gap + 8'd1;
        if ((trk_phase == TRK_PRESSED || trk_phase == TRK_CONFIRM_RELEASE)
            && trk_held != HELD_MAX)
            trk_held = trk_held + 16'd1;
        if ((trk_phase == TRK_CONFIRM_PRESS || trk_phase == TRK_CONFIRM_RELEASE)
            && trk_debounce != DEBOUNCE_MAX)
            trk_debounce = trk_debounce + 8'd1;

        case (trk_phase)
            TRK_IDLE:
            begin
                // Multi-click targets are checked only once the gap has expired.
                if (trk_gap > trk_cfg.multiclick_gap)
                begin
                    if (trk_cfg.multiclick_enable[0] && !trk_mc_done[0]
                        && {1'b0, trk_cfg.click_target_a} == want)
                        r.multiclick_fired[0] = 1'b1;
                    if (trk_cfg.multiclick_enable[1] && !trk_mc_done[1]
                        && {1'b0, trk_cfg.click_target_b} == want)
                        r.multiclick_fired[1] = 1'b1;
                    trk_mc_done = trk_mc_done | r.multiclick_fired;
                end
                if (pin)
                begin
                    trk_debounce = '0;
                    nxt = TRK_CONFIRM_PRESS;
                end
            end
            TRK_CONFIRM_PRESS:
            begin
                if (trk_debounce >= trk_cfg.debounce_ticks)
                begin
                    if (pin)
                    begin
                        trk_held = '0;
                        if (trk_gap <= trk_cfg.multiclick_gap)
                        begin
                            if (trk_clicks != CLICK_MAX)
                                trk_clicks = trk_clicks + 4'd1;
                        end
                        else
                        begin
                            trk_clicks  = '0;
                            trk_mc_done = '0;
                        end
                        r.press_fired = 1'b1;
                        nxt = TRK_PRESSED;
                    end
                    else
                        nxt = TRK_IDLE;
                end
            end
            TRK_PRESSED:
            begin
                if (!pin)
                begin
                    trk_debounce = '0;
                    nxt = TRK_CONFIRM_RELEASE;
                end
                else
                begin
                    r.hold_fired = 1'b1;
                    if (trk_cfg.longpress_enable[0] && !trk_lp_done[0]
                        && trk_held >= trk_cfg.hold_after_a)
                        r.longpress_fired[0] = 1'b1;
                    if (trk_cfg.longpress_enable[1] && !trk_lp_done[1]
                        && trk_held >= trk_cfg.hold_after_b)
                        r.longpress_fired[1] = 1'b1;
                    trk_lp_done = trk_lp_done | r.longpress_fired;
                end
            end
            default:
            begin
                if (trk_debounce >= trk_cfg.debounce_ticks)
                begin
                    if (!pin)
                    begin
                        trk_last_len    = trk_held;
                        trk_lp_done     = '0;
                        trk_held        = '0;
                        trk_gap         = '0;
                        r.release_fired = 1'b1;
                        nxt = TRK_IDLE;
                    end
                    else
                        nxt = TRK_PRESSED;
                end
            end
        endcase
        trk_phase = nxt;

        r.press_length   = trk_last_len;
        r.current_length = trk_held;
        r.click_tally    = trk_clicks;
        return r;
    endfunction

    function automatic string describe(input bdc_result_t r);
        return $sformatf("press=%0d rel=%0d hold=%0d long=%0d multi=%0d plen=%0d cur=%0d n=%0d",
                         r.press_fired, r.release_fired, r.hold_fired, r.longpress_fired,
                         r.multiclick_fired, r.press_length, r.current_length, r.click_tally);
    endfunction

    // Queue n ticks of one pin level.
    task automatic add_level(input logic lvl, input int n);
        for (int i = 0; i < n; i++)
        begin
            pin_samples = {pin_samples, lvl};
            samples_queued++;
        end
    endtask

    // Wait until every queued tick has been taken and every result has come back.
    task automatic wait_drained();
        while (samples_taken != samples_queued || expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all registers while the block is idle; narrow fields get junk upper bits.
    task automatic write_all(input bdc_cfg_t c);
        wait_drained();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_DEBOUNCE_TICKS;
        cfg_data  <= (16'($urandom) & 16'hFF00) | 16'(c.debounce_ticks);
        @(posedge clk);
        cfg_index <= REG_MULTICLICK_GAP;
        cfg_data  <= (16'($urandom) & 16'hFF00) | 16'(c.multiclick_gap);
        @(posedge clk);
        cfg_index <= REG_HOLD_AFTER_A;
        cfg_data  <= c.hold_after_a;
        @(posedge clk);
        cfg_index <= REG_HOLD_AFTER_B;
        cfg_data  <= c.hold_after_b;
        @(posedge clk);
        cfg_index <= REG_CLICK_TARGET_A;
        cfg_data  <= (16'($urandom) & 16'hFFF0) | 16'(c.click_target_a);
        @(posedge clk);
        cfg_index <= REG_CLICK_TARGET_B;
        cfg_data  <= (16'($urandom) & 16'hFFF0) | 16'(c.click_target_b);
        @(posedge clk);
        cfg_index <= REG_LONGPRESS_ENABLE;
        cfg_data  <= (16'($urandom) & 16'hFFFC) | 16'(c.longpress_enable);
        @(posedge clk);
        cfg_index <= REG_MULTICLICK_ENABLE;
        cfg_data  <= (16'($urandom) & 16'hFFFC) | 16'(c.multiclick_enable);
        @(posedge clk);
        cfg_write <= 1'b0;
        trk_cfg = c;
    endtask

    // Sender: predicts each accepted beat and offers the next one in bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_events = {expected_events, tracker_tick(pin_level)};
                samples_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pin_samples.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    pin_level <= pin_samples.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall runs, calm stretches, and long hold-offs on request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_off_req != hold_off_done)
            begin
                hold_off_done++;
                hold_left = HoldOffCycles;
                out_stall <= 1'b1;
            end
            else
            begin
                if (stall_run == 0)
                begin
                    stall_level = !stall_level;
                    if (stall_level)
                        stall_run = $urandom_range(1, 6);
                    else if ($urandom_range(0, 3) == 0)
                        stall_run = $urandom_range(20, 60);
                    else
                        stall_run = $urandom_range(1, 8);
                end
                stall_run--;
                out_stall <= stall_level;
            end
        end
    end

    // Monitor: every result beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result beat: %s", describe(seen));
                mismatch_count++;
            end
            else
            begin
                wanted = expected_events.pop_front();
                if (seen !== wanted)
                begin
                    if (mismatch_count < 10)
                        $display("result mismatch\n  expected %s\n  actual   %s",
                                 describe(wanted), describe(seen));
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        bdc_cfg_t cfg;
        int       deb;
        int       gap;
        int       kind;
        int       phase_end;

        // Tracker state after reset.
        trk_cfg = '{DEBOUNCE_TICKS_RST, MULTICLICK_GAP_RST, HOLD_AFTER_A_RST, HOLD_AFTER_B_RST,
                    CLICK_TARGET_A_RST, CLICK_TARGET_B_RST, LONGPRESS_ENABLE_RST,
                    MULTICLICK_ENABLE_RST};
        trk_phase    = TRK_IDLE;
        trk_debounce = '0;
        trk_held     = '0;
        trk_gap      = GAP_MAX;
        trk_clicks   = '0;
        trk_lp_done  = '0;
        trk_mc_done  = '0;
        trk_last_len = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: short debounce and gap, thresholds of zero and two,
        // targets of one and two, everything enabled.
        cfg = '{8'd1, 8'd3, 16'd2, 16'd0, 4'd1, 4'd2, 2'd3, 2'd3};
        write_all(cfg);
        add_level(1'b0, 1);     // gap expired at reset, target one fires at once
        add_level(1'b1, 1);     // bounce during press confirmation
        add_level(1'b0, 1);
        add_level(1'b1, 5);     // press, then hold with both long-press events
        add_level(1'b0, 1);     // bounce during release confirmation
        add_level(1'b1, 2);
        add_level(1'b0, 3);     // release, then one idle tick
        add_level(1'b1, 3);     // second press inside the gap
        add_level(1'b0, 6);     // release, gap expires, target two fires

        // Random phases; the first one restores the reset values.
        for (int p = 0; p < RandomPhases; p++)
        begin
            if (p == 0)
                cfg = '{DEBOUNCE_TICKS_RST, MULTICLICK_GAP_RST, HOLD_AFTER_A_RST,
                        HOLD_AFTER_B_RST, CLICK_TARGET_A_RST, CLICK_TARGET_B_RST,
                        LONGPRESS_ENABLE_RST, MULTICLICK_ENABLE_RST};
            else
            begin
                cfg.debounce_ticks = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 40))
                                                                  : 8'($urandom_range(1, 6));
                case ($urandom_range(0, 3))
                    0:       cfg.multiclick_gap = 8'd0;
                    1:       cfg.multiclick_gap = 8'd255;
                    default: cfg.multiclick_gap = 8'($urandom_range(1, 40));
                endcase
                cfg.hold_after_a = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 40));
                cfg.hold_after_b = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 40));
                cfg.click_target_a = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15))
                                                                  : 4'($urandom_range(1, 4));
                cfg.click_target_b = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15))
                                                                  : 4'($urandom_range(1, 4));
                cfg.longpress_enable  = 2'($urandom);
                cfg.multiclick_enable = 2'($urandom);
            end
            write_all(cfg);
            if (p == 1 || p == 4)
                hold_off_req++;

            deb = int'(cfg.debounce_ticks);
            gap = int'(cfg.multiclick_gap);
            phase_end = samples_queued + PhaseBeats;
            while (samples_queued < phase_end)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                begin
                    // Clean click: confirmed press, optional release bounce, then
                    // an idle stretch inside or beyond the multi-click gap.
                    add_level(1'b1, deb + 1 + (($urandom_range(0, 3) == 0)
                                               ? $urandom_range(0, 60)
                                               : $urandom_range(0, 12)));
                    if ($urandom_range(0, 4) == 0)
                    begin
                        add_level(1'b0, $urandom_range(1, deb));
                        add_level(1'b1, $urandom_range(1, 6));
                    end
                    add_level(1'b0, deb + 1 + ($urandom_range(0, 1) ? $urandom_range(0, gap)
                                                                   : gap + $urandom_range(1, 40)));
                end
                else if (kind < 9)
                begin
                    // Glitch shorter than the debounce wait.
                    add_level(1'b1, $urandom_range(1, deb));
                    add_level(1'b0, $urandom_range(1, deb + 2));
                end
                else
                begin
                    repeat ($urandom_range(1, 10)) add_level(1'($urandom), 1);
                end
            end
        end

        // Click counter saturation: series of 18, 15 and 14 quick clicks, each
        // followed by an idle stretch past the gap.
        cfg = '{8'd1, 8'd10, 16'd5, 16'd9, 4'd15, 4'd14, 2'd1, 2'd3};
        write_all(cfg);
        for (int s = 0; s < 3; s++)
        begin
            repeat ((s == 0) ? 18 : (s == 1) ? 15 : 14)
            begin
                add_level(1'b1, 3);
                add_level(1'b0, 4);
            end
            add_level(1'b0, 20);
        end

        // Longest debounce with a zero gap.
        cfg = '{8'd255, 8'd0, 16'd100, 16'd65535, 4'd1, 4'd15, 2'd3, 2'd3};
        write_all(cfg);
        add_level(1'b1, 260);
        add_level(1'b0, 270);

        wait_drained();
        repeat (TailCycles) @(posedge clk);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[button_debounce_click_detector.f]
design/bdc_pkg.sv
design/bdc_cfg_regs.sv
design/bdc_step.sv
design/button_debounce_click_detector.sv
tb/testbench.sv
